// ----- rtl/core/jd2cal_pkg.sv -----
// ----------------------------------------------------------------------------
// jd2cal_pkg
// Shared types, constants and tables for the Julian day number to calendar
// date converter.
// ----------------------------------------------------------------------------
package jd2cal_pkg;

   // Word field widths
   localparam int DayNumberWidth = 23;
   localparam int MonthWidth     = 4;
   localparam int DomWidth       = 5;
   localparam int YearWidth      = 15;

   typedef logic        [DayNumberWidth-1:0] day_number_type;
   typedef logic        [MonthWidth-1:0]     month_type;
   typedef logic        [DomWidth-1:0]       dom_type;
   typedef logic signed [YearWidth-1:0]      year_type;

   // Pipeline depth
   localparam int StageCount = 10;

   // Calendar constants
   localparam int GregStart = 2299161;
   localparam int GregEpoch = 1867216;
   localparam int DayOffset = 1524;
   localparam int YearBase  = 4715;
   localparam int FourCent  = 146097;
   localparam int YearDiv   = 36525;
   localparam int YearBias  = 12210;
   localparam int MonthNum  = 306001;
   localparam int MonthDen  = 10000;

   // Century count: 4*(jd - epoch) - 1 over FourCent, by reciprocal
   localparam int CentNumWidth = 25;
   localparam int CentShift    = CentNumWidth;
   localparam int CentQWidth   = 8;
   localparam int CentRemWidth = 19;
   localparam logic [CentQWidth-1:0] CentRecip =
      CentQWidth'((64'd1 << CentShift) / FourCent);
   localparam logic [CentNumWidth-1:0] CentBias = CentNumWidth'(4 * GregEpoch + 1);

   // Year count: (100*b - 12210) over 36525, by reciprocal
   localparam int BWidth       = 24;
   localparam int YearNumWidth = 30;
   localparam int YearShift    = YearNumWidth;
   localparam int CWidth       = 15;
   localparam int YearRemWidth = 17;
   localparam logic [CWidth-1:0] YearRecip = CWidth'((64'd1 << YearShift) / YearDiv);

   // Month count: 10000*bd over 306001, by reciprocal on bd
   localparam int BdWidth    = 9;
   localparam int MonthShift = 20;
   localparam int RecipWidth = 16;
   localparam int EWidth     = 4;
   localparam logic [RecipWidth-1:0] MonthRecip =
      RecipWidth'((64'd10000 << MonthShift) / MonthNum);

   // Days before month index e: floor(30.6001 * e)
   function automatic logic [BdWidth-1:0] month_offset(input logic [EWidth-1:0] e);
      logic [BdWidth-1:0] off;
      case (e)
         4'd0:    off = 9'd0;
         4'd1:    off = 9'd30;
         4'd2:    off = 9'd61;
         4'd3:    off = 9'd91;
         4'd4:    off = 9'd122;
         4'd5:    off = 9'd153;
         4'd6:    off = 9'd183;
         4'd7:    off = 9'd214;
         4'd8:    off = 9'd244;
         4'd9:    off = 9'd275;
         4'd10:   off = 9'd306;
         4'd11:   off = 9'd336;
         4'd12:   off = 9'd367;
         4'd13:   off = 9'd397;
         4'd14:   off = 9'd428;
         4'd15:   off = 9'd459;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

// ----- rtl/core/jd2cal_req_if.sv -----
// ----------------------------------------------------------------------------
// jd2cal_req_if
// Request channel: one Julian day number per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jd2cal_req_if;
   import jd2cal_pkg::*;

   logic           valid;
   logic           ready;
   day_number_type day_number;

   modport source (output valid, output day_number, input ready);
   modport sink   (input valid, input day_number, output ready);
endinterface

// ----- rtl/core/jd2cal_rsp_if.sv -----
// ----------------------------------------------------------------------------
// jd2cal_rsp_if
// Response channel: one calendar date per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jd2cal_rsp_if;
   import jd2cal_pkg::*;

   logic      valid;
   logic      ready;
   month_type month;
   dom_type   day_of_month;
   year_type  year;

   modport source (output valid, output month, output day_of_month, output year,
                   input ready);
   modport sink   (input valid, input month, input day_of_month, input year,
                   output ready);
endinterface

// ----- rtl/core/julian_day_to_calendar_date_core.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_core
// Converts a Julian day number to month, day of month and year, with the
// Gregorian century correction from day 2299161 on and no year zero.
//
//   channel    direction  payload                        handshake
//   req_chan   in         day_number                     valid / ready
//   rsp_chan   out        month, day_of_month, year      valid / ready
//
// Ten register stages; one word enters per cycle unless all ten hold a word and rsp_chan stalls.
// The three constant divisions are reciprocal multiplies with one
// compare-and-correct step each, and they set the stage count.
// Reset (synchronous) clears the stage valid bits only.
// A stall on rsp_chan backs up only through full stages; bubbles close up,
// so req_chan.ready drops only when all ten stages hold a word.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_core (
   input  logic             clock,
   input  logic             reset,
   jd2cal_req_if.sink       req_chan,
   jd2cal_rsp_if.source     rsp_chan
);
   import jd2cal_pkg::*;

   localparam int LastStage = StageCount - 1;

   // Stage valid bits and advance chain
   logic [StageCount-1:0] vld_ff;
   logic [StageCount-1:0] adv;

   always_comb begin
      adv[LastStage] = !vld_ff[LastStage] || rsp_chan.ready;
      for (int k = LastStage - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_chan.valid;
         for (int k = 1; k < StageCount; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage 0: capture day number, Gregorian flag, century numerator
   logic [BWidth-1:0]       s0_jd_ff,   s0_jd_in;
   logic                    s0_greg_ff, s0_greg_in;
   logic [CentNumWidth-1:0] s0_num_ff,  s0_num_in;

   always_comb begin
      s0_jd_in   = BWidth'(req_chan.day_number);
      s0_greg_in = req_chan.day_number >= DayNumberWidth'(GregStart);
      s0_num_in  = (CentNumWidth'(req_chan.day_number) << 2) - CentBias;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_jd_ff   <= s0_jd_in;
         s0_greg_ff <= s0_greg_in;
         s0_num_ff  <= s0_num_in;
      end
   end

   // Stage 1: century reciprocal product
   localparam int P1Width = CentNumWidth + CentQWidth;
   logic [BWidth-1:0]       s1_jd_ff;
   logic                    s1_greg_ff;
   logic [CentNumWidth-1:0] s1_num_ff;
   logic [P1Width-1:0]      s1_prod_ff, s1_prod_in;

   assign s1_prod_in = P1Width'(s0_num_ff) * P1Width'(CentRecip);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_jd_ff   <= s0_jd_ff;
         s1_greg_ff <= s0_greg_ff;
         s1_num_ff  <= s0_num_ff;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Stage 2: century estimate and remainder
   logic [BWidth-1:0]       s2_jd_ff;
   logic                    s2_greg_ff;
   logic [CentQWidth-1:0]   s2_q_ff,   s2_q_in;
   logic [CentRemWidth-1:0] s2_rem_ff, s2_rem_in;
   logic [CentNumWidth-1:0] s2_rem_full;

   always_comb begin
      s2_q_in     = s1_prod_ff[P1Width-1 -: CentQWidth];
      s2_rem_full = s1_num_ff - (CentNumWidth'(s2_q_in) * CentNumWidth'(FourCent));
      s2_rem_in   = s2_rem_full[CentRemWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_jd_ff   <= s1_jd_ff;
         s2_greg_ff <= s1_greg_ff;
         s2_q_ff    <= s2_q_in;
         s2_rem_ff  <= s2_rem_in;
      end
   end

   // Stage 3: century correction, shifted day count b, year numerator
   logic [BWidth-1:0]       s3_b_ff,   s3_b_in;
   logic [YearNumWidth-1:0] s3_num_ff, s3_num_in;
   logic [CentQWidth-1:0]   s3_cent;
   logic [BWidth-1:0]       s3_a;

   always_comb begin
      s3_cent = s2_q_ff + CentQWidth'(s2_rem_ff >= CentRemWidth'(FourCent));
      if (s2_greg_ff) begin
         s3_a = s2_jd_ff + BWidth'(1) + BWidth'(s3_cent) - BWidth'(s3_cent >> 2);
      end else begin
         s3_a = s2_jd_ff;
      end
      s3_b_in   = s3_a + BWidth'(DayOffset);
      s3_num_in = (YearNumWidth'(s3_b_in) * YearNumWidth'(100)) - YearNumWidth'(YearBias);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_b_ff   <= s3_b_in;
         s3_num_ff <= s3_num_in;
      end
   end

   // Stage 4: year reciprocal product
   localparam int P2Width = YearNumWidth + CWidth;
   logic [BWidth-1:0]       s4_b_ff;
   logic [YearNumWidth-1:0] s4_num_ff;
   logic [P2Width-1:0]      s4_prod_ff, s4_prod_in;

   assign s4_prod_in = P2Width'(s3_num_ff) * P2Width'(YearRecip);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_b_ff    <= s3_b_ff;
         s4_num_ff  <= s3_num_ff;
         s4_prod_ff <= s4_prod_in;
      end
   end

   // Stage 5: year estimate and remainder
   logic [BWidth-1:0]       s5_b_ff;
   logic [CWidth-1:0]       s5_c_ff,   s5_c_in;
   logic [YearRemWidth-1:0] s5_rem_ff, s5_rem_in;
   logic [YearNumWidth-1:0] s5_rem_full;

   always_comb begin
      s5_c_in     = s4_prod_ff[P2Width-1 -: CWidth];
      s5_rem_full = s4_num_ff - (YearNumWidth'(s5_c_in) * YearNumWidth'(YearDiv));
      s5_rem_in   = s5_rem_full[YearRemWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_b_ff   <= s4_b_ff;
         s5_c_ff   <= s5_c_in;
         s5_rem_ff <= s5_rem_in;
      end
   end

   // Stage 6: corrected year count c, day within year bd = b - d
   logic [CWidth-1:0]  s6_c_ff,  s6_c_in;
   logic [BdWidth-1:0] s6_bd_ff, s6_bd_in;
   logic [BWidth-1:0]  s6_d;
   logic [BWidth-1:0]  s6_diff;

   always_comb begin
      s6_c_in  = s5_c_ff + CWidth'(s5_rem_ff >= YearRemWidth'(YearDiv));
      s6_d     = (BWidth'(s6_c_in) * BWidth'(365)) + BWidth'(s6_c_in >> 2);
      s6_diff  = s5_b_ff - s6_d;
      s6_bd_in = s6_diff[BdWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_c_ff  <= s6_c_in;
         s6_bd_ff <= s6_bd_in;
      end
   end

   // Stage 7: month reciprocal product
   localparam int P3Width = BdWidth + RecipWidth;
   logic [CWidth-1:0]  s7_c_ff;
   logic [BdWidth-1:0] s7_bd_ff;
   logic [P3Width-1:0] s7_prod_ff, s7_prod_in;

   assign s7_prod_in = P3Width'(s6_bd_ff) * P3Width'(MonthRecip);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_c_ff    <= s6_c_ff;
         s7_bd_ff   <= s6_bd_ff;
         s7_prod_ff <= s7_prod_in;
      end
   end

   // Stage 8: month index e with one-step correction
   localparam int MNumWidth = 23;
   logic [CWidth-1:0]    s8_c_ff;
   logic [BdWidth-1:0]   s8_bd_ff;
   logic [EWidth-1:0]    s8_e_ff, s8_e_in;
   logic [EWidth-1:0]    s8_e0;
   logic [EWidth:0]      s8_e1;
   logic [MNumWidth-1:0] s8_lhs;
   logic [MNumWidth-1:0] s8_rhs;

   always_comb begin
      s8_e0   = s7_prod_ff[MonthShift +: EWidth];
      s8_e1   = {1'b0, s8_e0} + (EWidth+1)'(1);
      s8_lhs  = MNumWidth'(s7_bd_ff) * MNumWidth'(MonthDen);
      s8_rhs  = MNumWidth'(s8_e1) * MNumWidth'(MonthNum);
      s8_e_in = (s8_lhs >= s8_rhs) ? s8_e1[EWidth-1:0] : s8_e0;
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_c_ff  <= s7_c_ff;
         s8_bd_ff <= s7_bd_ff;
         s8_e_ff  <= s8_e_in;
      end
   end

   // Stage 9: month, day and year, output register
   localparam int YWidth = CWidth + 2;
   month_type          s9_month_ff, s9_month_in;
   dom_type            s9_dom_ff,   s9_dom_in;
   year_type           s9_year_ff,  s9_year_in;
   logic [BdWidth-1:0] s9_day_full;
   logic signed [YWidth-1:0] s9_y0, s9_y1, s9_y2;

   always_comb begin
      s9_day_full = s8_bd_ff - month_offset(s8_e_ff);
      s9_dom_in   = s9_day_full[DomWidth-1:0];
      s9_month_in = s8_e_ff - MonthWidth'(1);
      if (s9_month_in > MonthWidth'(12)) begin
         s9_month_in = s9_month_in - MonthWidth'(12);
      end
      s9_y0 = $signed(YWidth'(s8_c_ff)) - YWidth'(YearBase);
      s9_y1 = (s9_month_in > MonthWidth'(2)) ? s9_y0 - YWidth'(1) : s9_y0;
      s9_y2 = (s9_y1 <= 0) ? s9_y1 - YWidth'(1) : s9_y1;
      s9_year_in = s9_y2[YearWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s9_month_ff <= s9_month_in;
         s9_dom_ff   <= s9_dom_in;
         s9_year_ff  <= s9_year_in;
      end
   end

   assign rsp_chan.valid        = vld_ff[LastStage];
   assign rsp_chan.month        = s9_month_ff;
   assign rsp_chan.day_of_month = s9_dom_ff;
   assign rsp_chan.year         = s9_year_ff;

   // Checks
   month_range_a: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.month >= MonthWidth'(1) &&
                          rsp_chan.month <= MonthWidth'(12)))
      else $error("month out of range");

   day_nonzero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.day_of_month != '0))
      else $error("day of month is zero");

   full_only_stall_a: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&vld_ff && !rsp_chan.ready))
      else $error("request stalled with room in pipeline");

   accept_lands_a: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted word missing from first stage");

endmodule

// ----- tb/tb_julian_day_to_calendar_date_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Julian day number to calendar date converter.
// Day numbers go in over req_chan, and each one is converted by a behavioral
// calendar model kept in a small scoreboard. Dates coming back on rsp_chan
// are matched in order, field by field. Both channels idle and stall at
// random, and the response side holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb;
   import jd2cal_pkg::*;

   localparam int  ClockHalf   = 4;
   localparam int  ResetCycles = 11;
   localparam int  RandomDays  = 500;
   localparam int  QuietLimit  = 2000;
   localparam int  DrainCycles = 2 * StageCount;
   localparam int  HoldCycles  = 80;
   localparam int  LastDay     = 5373484;
   localparam int  FirstAd     = 1721424;

   typedef struct packed {
      month_type month;
      dom_type   day_of_month;
      year_type  year;
   } calendar_date_type;

   // Expected dates in arrival order, plus the date arithmetic behind them
   class date_scoreboard;
      calendar_date_type dates_due[$];
      int                mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Exact integer form of the day-number conversion
      function calendar_date_type date_of(day_number_type dn);
         longint jd, cent, a, b, c, d, e, m, y, dom;
         calendar_date_type r;
         jd = longint'(dn);
         if (jd >= GregStart) begin
            cent = (4 * (jd - GregEpoch) - 1) / FourCent;
            a = jd + 1 + cent - cent / 4;
         end else begin
            a = jd;
         end
         b = a + DayOffset;
         c = (100 * b - YearBias) / YearDiv;
         d = 365 * c + c / 4;
         e = (MonthDen * (b - d)) / MonthNum;
         dom = b - d - (MonthNum * e) / MonthDen;
         m = e - 1;
         if (m > 12) m = m - 12;
         y = c - YearBase;
         if (m > 2) y = y - 1;
         // no year zero: 1 BC is -1
         if (y <= 0) y = y - 1;
         r.month        = month_type'(m);
         r.day_of_month = dom_type'(dom);
         r.year         = year_type'(y);
         return r;
      endfunction

      function void note_day(day_number_type dn);
         dates_due.push_back(date_of(dn));
      endfunction

      function void check_date(month_type mo, dom_type dm, year_type yr);
         calendar_date_type want;
         if (dates_due.size() == 0) begin
            $error("date word with none expected: month %0d day_of_month %0d year %0d",
                   mo, dm, yr);
            mismatches++;
            return;
         end
         want = dates_due.pop_front();
         if (mo !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, mo);
            mismatches++;
         end
         if (dm !== want.day_of_month) begin
            $error("day_of_month: expected %0d, got %0d", want.day_of_month, dm);
            mismatches++;
         end
         if (yr !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, yr);
            mismatches++;
         end
      endfunction

      function int pending();
         return dates_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   jd2cal_req_if req_chan ();
   jd2cal_rsp_if rsp_chan ();

   date_scoreboard sb = new();

   julian_day_to_calendar_date_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Offer one day number and hold it until taken; optional gap afterwards
   task automatic send_day(input day_number_type dn, input bit steady);
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.day_number <= dn;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_day(dn);
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pick a day number, weighted toward the calendar seams
   function automatic day_number_type random_day();
      int r;
      r = $urandom_range(0, 99);
      if (r < 66) return day_number_type'($urandom_range(0, LastDay));
      if (r < 76) return day_number_type'($urandom_range(GregStart - 400, GregStart + 400));
      if (r < 84) return day_number_type'($urandom_range(FirstAd - 800, FirstAd + 800));
      if (r < 90) return day_number_type'($urandom_range(LastDay - 200, LastDay));
      // above the supported range, year wraps
      return day_number_type'($urandom_range(LastDay + 1, (1 << DayNumberWidth) - 1));
   endfunction

   // Stimulus and end of run
   initial begin
      day_number_type directed_days[$];
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.day_number <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_days = '{
         23'd0,                      // earliest day
         23'd1,
         23'd2299160,                // last Julian-calendar day
         23'd2299161,                // first Gregorian day
         23'd1721423,                // last day of 1 BC
         23'd1721424,                // first day of 1 AD
         23'd1721058,                // first day of 1 BC
         23'd1721059,
         23'd2415079,                // 1900 is no Gregorian leap year
         23'd2415080,
         23'd2451604,                // 2000 leap day
         23'd2451605,
         23'd2451544,                // turn of the millennium
         23'd2451545,
         23'd5373483,
         23'd5373484,                // last supported day
         23'd5373485,                // first day past range
         23'h7FFFFF,                 // all ones, year wraps
         23'h2AAAAA,
         23'h555555
      };
      foreach (directed_days[i]) send_day(directed_days[i], 1'b0);

      for (int i = 0; i < RandomDays; i++) begin
         send_day(random_day(), ((i / 48) % 4) == 0);
      end
      req_chan.valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("[julian_day_to_calendar_date_core] OK");
      end else begin
         $display("[julian_day_to_calendar_date_core] ERROR");
      end
      $finish;
   end

   // Response side: check each date word, then pick next cycle's ready
   initial begin
      int hold_left;
      int calm_left;
      int seen;
      int r;
      hold_left = 0;
      calm_left = 0;
      seen      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            sb.check_date(rsp_chan.month, rsp_chan.day_of_month, rsp_chan.year);
            seen++;
            // long hold-off so the pipeline fills and stalls the input
            if (seen == 100 || seen == 350) hold_left = HoldCycles;
         end
         if (hold_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 4)       calm_left = $urandom_range(30, 120);
            else if (r < 30) hold_left = gap_length();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left--;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too many cycles with no word moving on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[julian_day_to_calendar_date_core] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/jd2cal_pkg.sv
rtl/core/jd2cal_req_if.sv
rtl/core/jd2cal_rsp_if.sv
rtl/core/julian_day_to_calendar_date_core.sv
tb/tb_julian_day_to_calendar_date_core.sv
